@@ sv/ata_pio_read_device_assert.svh @@
// Assertion macros used by the checker file.
`ifndef ATA_PIO_READ_DEVICE_ASSERT_SVH
`define ATA_PIO_READ_DEVICE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define APR_ASSERT_IMP(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define APR_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("assertion failed");
`endif

@@ sv/apr_pkg.sv @@
// ----------------------------------------------------------------------------
// apr_pkg
// Shared types, codes and constants of the ATA PIO read device.
// ----------------------------------------------------------------------------
package apr_pkg;
  localparam int HEADS_DEFAULT = 16;
  localparam int SPT_DEFAULT   = 63;

  localparam logic [1:0] OP_BYTE_READ  = 2'd0;
  localparam logic [1:0] OP_BYTE_WRITE = 2'd1;
  localparam logic [1:0] OP_WORD_READ  = 2'd2;

  localparam logic [15:0] PORT_DATA    = 16'h01F0;
  localparam logic [15:0] PORT_ERROR   = 16'h01F1;
  localparam logic [15:0] PORT_COUNT   = 16'h01F2;
  localparam logic [15:0] PORT_SECTOR  = 16'h01F3;
  localparam logic [15:0] PORT_CYL_LO  = 16'h01F4;
  localparam logic [15:0] PORT_CYL_HI  = 16'h01F5;
  localparam logic [15:0] PORT_DRVHEAD = 16'h01F6;
  localparam logic [15:0] PORT_CMD     = 16'h01F7;
  localparam logic [15:0] PORT_CTRL    = 16'h03F6;

  localparam logic [7:0] ST_IDLE  = 8'h50;
  localparam logic [7:0] ST_DRQW  = 8'h58;
  localparam logic [7:0] ST_ABORT = 8'h41;
  localparam logic [7:0] ER_ABORT = 8'h04;

  localparam logic [7:0] CMD_IDENTIFY = 8'hEC;
  localparam logic [7:0] CMD_READ     = 8'h20;
  localparam logic [7:0] CMD_READ_NR  = 8'h21;
  localparam logic [7:0] CMD_DIAG     = 8'h90;
  localparam logic [7:0] CMD_INITP    = 8'h91;
  localparam logic [7:0] CMD_SETMULT  = 8'hC6;
  localparam logic [7:0] CMD_SETFEAT  = 8'hEF;

  localparam logic [0:0] CFG_TOTAL = 1'd0;
  localparam logic [0:0] CFG_CYLS  = 1'd1;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] port_address;
    logic [7:0]  write_value;
    logic [15:0] disk_word;
  } req_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic        irq_line;
    logic        transfer_active;
    logic [27:0] sector_address;
    logic [8:0]  word_position;
  } rsp_t;

  typedef struct packed {
    logic [7:0]  error_reg;
    logic [7:0]  count_reg;
    logic [7:0]  sector_reg;
    logic [7:0]  cyl_low_reg;
    logic [7:0]  cyl_high_reg;
    logic [7:0]  drive_head_reg;
    logic [7:0]  status_reg;
    logic [7:0]  device_control_reg;
    logic        data_request;
    logic        identify_mode;
    logic        irq_pending;
    logic [27:0] transfer_sector;
    logic [8:0]  sectors_remaining;
    logic [8:0]  word_counter;
  } tf_t;

  localparam tf_t TF_RESET = '{
    error_reg: 8'h00, count_reg: 8'h01, sector_reg: 8'h01, cyl_low_reg: 8'h00,
    cyl_high_reg: 8'h00, drive_head_reg: 8'hA0, status_reg: ST_IDLE,
    device_control_reg: 8'h00, data_request: 1'b0, identify_mode: 1'b0,
    irq_pending: 1'b0, transfer_sector: 28'd0, sectors_remaining: 9'd0,
    word_counter: 9'd0};

  // Fixed words of the identify table; configuration dependent words are
  // handled by the caller.
  function automatic logic [15:0] id_fixed(input logic [7:0] i);
    logic [15:0] w;
    w = 16'h0000;
    unique case (i)
      8'd0: w = 16'h0040;   8'd5: w = 16'h0200;   8'd10: w = 16'h514d;
      8'd11: w = 16'h3030;  8'd12: w = 16'h3030;  8'd13: w = 16'h3120;
      8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd19: w = 16'h2020;
      8'd20: w = 16'h0003;  8'd21: w = 16'h0200;  8'd22: w = 16'h0004;
      8'd23: w = 16'h322e;  8'd24: w = 16'h352b;  8'd25: w = 16'h2020;
      8'd26: w = 16'h2020;  8'd27: w = 16'h5145;  8'd28: w = 16'h4d55;
      8'd29: w = 16'h2048;  8'd30: w = 16'h4152;  8'd31: w = 16'h4444;
      8'd32: w = 16'h4953;  8'd33: w = 16'h4b20;
      8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd40, 8'd41, 8'd42, 8'd43,
      8'd44, 8'd45, 8'd46: w = 16'h2020;
      8'd47: w = 16'h8010;  8'd48: w = 16'h0001;  8'd49: w = 16'h0b00;
      8'd51: w = 16'h0200;  8'd52: w = 16'h0200;  8'd53: w = 16'h0007;
      8'd59: w = 16'h0110;  8'd62: w = 16'h0007;  8'd63: w = 16'h0007;
      8'd64: w = 16'h0003;
      8'd65, 8'd66, 8'd67, 8'd68: w = 16'h0078;
      8'd69: w = 16'h4000;  8'd80: w = 16'h00f0;  8'd81: w = 16'h0016;
      8'd82: w = 16'h4021;  8'd83: w = 16'h7400;  8'd84: w = 16'h4000;
      8'd85: w = 16'h4021;  8'd86: w = 16'h3400;  8'd87: w = 16'h4000;
      8'd88: w = 16'h203f;  8'd93: w = 16'h6001;  8'd106: w = 16'h6000;
      8'd169: w = 16'h0001;
      default: w = 16'h0000;
    endcase
    return w;
  endfunction
endpackage

@@ sv/apr_stream_if.sv @@
// ----------------------------------------------------------------------------
// apr_stream_if
// Valid/ready channel carrying one payload of a chosen type.
// ----------------------------------------------------------------------------
interface apr_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

@@ sv/apr_cfg_if.sv @@
// ----------------------------------------------------------------------------
// apr_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface apr_cfg_if ();
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [27:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/apr_ident.sv @@
// ----------------------------------------------------------------------------
// apr_ident
// Identify word table: fixed words plus geometry and capacity words.
// ----------------------------------------------------------------------------
module apr_ident #(
  parameter int HEADS = apr_pkg::HEADS_DEFAULT,
  parameter int SECTORS_PER_TRACK = apr_pkg::SPT_DEFAULT
) (
  input  logic [7:0]  index,
  input  logic [15:0] cylinders,
  input  logic [15:0] chs_low,
  input  logic [15:0] chs_high,
  input  logic [27:0] disk_sectors,
  output logic [15:0] word
);
  import apr_pkg::*;
  localparam logic [15:0] H_W  = 16'(HEADS);
  localparam logic [15:0] S_W  = 16'(SECTORS_PER_TRACK);
  localparam logic [15:0] TRK_BYTES = 16'((512 * SECTORS_PER_TRACK) % 65536);

  always_comb begin
    unique case (index)
      8'd1, 8'd54:   word = cylinders;
      8'd3, 8'd55:   word = H_W;
      8'd4:          word = TRK_BYTES;
      8'd6, 8'd56:   word = S_W;
      8'd57:         word = chs_low;
      8'd58:         word = chs_high;
      8'd60, 8'd100: word = disk_sectors[15:0];
      8'd61:         word = {4'd0, disk_sectors[27:16]};
      default:       word = id_fixed(index);
    endcase
  end
endmodule

@@ sv/apr_core.sv @@
// ----------------------------------------------------------------------------
// apr_core
// Next-state and result logic for one bus access against the task file.
// ----------------------------------------------------------------------------
module apr_core #(
  parameter int HEADS = apr_pkg::HEADS_DEFAULT,
  parameter int SECTORS_PER_TRACK = apr_pkg::SPT_DEFAULT
) (
  input  apr_pkg::req_t  req,
  input  apr_pkg::tf_t   tf,
  input  logic [27:0]    disk_sectors,
  input  logic [15:0]    cylinders,
  input  logic [15:0]    chs_low,
  input  logic [15:0]    chs_high,
  input  logic [27:0]    chs_base,
  output apr_pkg::tf_t   tf_next,
  output apr_pkg::rsp_t  rsp
);
  import apr_pkg::*;

  logic        slave;
  logic [27:0] task_addr;
  logic [15:0] ident_w;
  logic [15:0] r;
  logic [8:0]  wc_inc;
  tf_t         t;

  apr_ident #(.HEADS(HEADS), .SECTORS_PER_TRACK(SECTORS_PER_TRACK)) u_ident (
    .index(tf.word_counter[7:0]), .cylinders(cylinders), .chs_low(chs_low),
    .chs_high(chs_high), .disk_sectors(disk_sectors), .word(ident_w));

  assign slave = tf.drive_head_reg[4];

  // chs_base holds (cyl*heads+head)*spt, formed from registered fields.
  always_comb begin
    if (tf.drive_head_reg[6]) begin
      task_addr = {tf.drive_head_reg[3:0], tf.cyl_high_reg, tf.cyl_low_reg,
                   tf.sector_reg};
    end else begin
      task_addr = chs_base + ((tf.sector_reg != 8'd0) ?
                  28'(tf.sector_reg - 8'd1) : 28'd0);
    end
  end

  assign wc_inc = tf.word_counter + 9'd1;

  always_comb begin
    t = tf;
    r = 16'd0;
    unique case (req.opcode)
      OP_BYTE_READ: begin
        unique case (req.port_address)
          PORT_ERROR:   r = slave ? 16'd0 : {8'd0, tf.error_reg};
          PORT_COUNT:   r = slave ? 16'd0 : {8'd0, tf.count_reg};
          PORT_SECTOR:  r = slave ? 16'd0 : {8'd0, tf.sector_reg};
          PORT_CYL_LO:  r = slave ? 16'd0 : {8'd0, tf.cyl_low_reg};
          PORT_CYL_HI:  r = slave ? 16'd0 : {8'd0, tf.cyl_high_reg};
          PORT_DRVHEAD: r = {8'd0, tf.drive_head_reg};
          PORT_CMD: begin
            t.irq_pending = 1'b0;
            r = slave ? 16'd0 : {8'd0, tf.status_reg};
          end
          PORT_CTRL:    r = slave ? 16'd0 : {8'd0, tf.status_reg};
          PORT_DATA:    r = 16'd0;
          default:      r = 16'h00FF;
        endcase
      end
      OP_BYTE_WRITE: begin
        unique case (req.port_address)
          PORT_COUNT:   if (!tf.data_request) t.count_reg = req.write_value;
          PORT_SECTOR:  if (!tf.data_request) t.sector_reg = req.write_value;
          PORT_CYL_LO:  if (!tf.data_request) t.cyl_low_reg = req.write_value;
          PORT_CYL_HI:  if (!tf.data_request) t.cyl_high_reg = req.write_value;
          PORT_DRVHEAD: t.drive_head_reg = req.write_value;
          PORT_CMD: begin
            if (!tf.data_request) begin
              unique case (req.write_value)
                CMD_IDENTIFY: begin
                  if (slave) begin
                    t.status_reg = 8'h00;
                  end else begin
                    t.identify_mode = 1'b1;
                    t.sectors_remaining = 9'd1;
                    t.word_counter = 9'd0;
                    t.data_request = 1'b1;
                    t.status_reg = ST_DRQW;
                    t.error_reg = 8'h00;
                    t.irq_pending = 1'b1;
                  end
                end
                CMD_READ, CMD_READ_NR: begin
                  if (slave) begin
                    t.status_reg = 8'h00;
                  end else if (task_addr >= disk_sectors) begin
                    t.status_reg = ST_ABORT;
                    t.error_reg = ER_ABORT;
                    t.irq_pending = 1'b1;
                  end else begin
                    t.transfer_sector = task_addr;
                    t.sectors_remaining = (tf.count_reg != 8'd0) ?
                                          {1'b0, tf.count_reg} : 9'd256;
                    t.identify_mode = 1'b0;
                    t.word_counter = 9'd0;
                    t.data_request = 1'b1;
                    t.status_reg = ST_DRQW;
                    t.error_reg = 8'h00;
                    t.irq_pending = 1'b1;
                  end
                end
                CMD_DIAG: begin
                  t.status_reg = ST_IDLE;
                  t.error_reg = 8'h01;
                  t.irq_pending = 1'b1;
                end
                CMD_INITP, CMD_SETMULT, CMD_SETFEAT: begin
                  t.status_reg = ST_IDLE;
                  t.irq_pending = 1'b1;
                end
                default: begin
                  t.status_reg = ST_ABORT;
                  t.error_reg = ER_ABORT;
                  t.irq_pending = 1'b1;
                end
              endcase
            end
          end
          PORT_CTRL: begin
            if (req.write_value[2] && !tf.device_control_reg[2]) begin
              t = TF_RESET;
            end
            t.device_control_reg = req.write_value;
          end
          default: ;
        endcase
      end
      OP_WORD_READ: begin
        if (req.port_address == PORT_DATA && tf.data_request) begin
          if (tf.identify_mode) begin
            r = ident_w;
          end else begin
            r = (tf.transfer_sector < disk_sectors) ? req.disk_word : 16'd0;
          end
          t.word_counter = wc_inc;
          if (wc_inc[8]) begin
            if (!tf.identify_mode && tf.sectors_remaining > 9'd1) begin
              t.sectors_remaining = tf.sectors_remaining - 9'd1;
              t.transfer_sector = tf.transfer_sector + 28'd1;
              t.word_counter = 9'd0;
              t.status_reg = ST_DRQW;
              t.irq_pending = 1'b1;
            end else begin
              t.data_request = 1'b0;
              t.identify_mode = 1'b0;
              t.status_reg = ST_IDLE;
              if (tf.drive_head_reg[6]) begin
                t.sector_reg = tf.transfer_sector[7:0];
                t.cyl_low_reg = tf.transfer_sector[15:8];
                t.cyl_high_reg = tf.transfer_sector[23:16];
                t.drive_head_reg = {tf.drive_head_reg[7:4],
                                    tf.transfer_sector[27:24]};
              end
              t.count_reg = 8'd0;
            end
          end
        end
      end
      default: ;
    endcase
    tf_next = t;
    rsp.read_data = r;
    rsp.irq_line = t.irq_pending && !t.device_control_reg[1];
    rsp.transfer_active = t.data_request;
    rsp.sector_address = t.transfer_sector;
    rsp.word_position = t.word_counter;
  end
endmodule

@@ sv/ata_pio_read_device.sv @@
// ----------------------------------------------------------------------------
// ata_pio_read_device
// Read-only ATA primary-master task file with PIO sector and identify reads.
// ----------------------------------------------------------------------------
// One bus request is taken per clock cycle and its response appears in the
// output register in the next cycle; the block takes a new request every
// cycle for as long as the response side keeps up, so throughput is one
// request per cycle. A response that is not taken holds the output register
// and stalls the request side until it drains.
// The pace is set by the single register stage that holds the task file,
// which every request reads and updates. The CHS start address and the
// identify geometry words need products of register values by the head and
// sector constants; these are formed combinationally from the current task
// file and configuration as constant multiplies of narrow fields, which
// synthesis reduces to a few adders, so every request sees up-to-date values
// and no extra register is needed.
module ata_pio_read_device #(
  parameter int HEADS = apr_pkg::HEADS_DEFAULT,
  parameter int SECTORS_PER_TRACK = apr_pkg::SPT_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  apr_cfg_if.sink    cfg,
  apr_stream_if.sink in_req,
  apr_stream_if.source out_rsp
);
  import apr_pkg::*;

  localparam int HS = HEADS * SECTORS_PER_TRACK;

  tf_t         tf;
  tf_t         tf_next;
  rsp_t        rsp;
  rsp_t        out_data;
  logic        out_valid;
  logic [27:0] disk_sectors;
  logic [15:0] cylinders;
  logic [31:0] chs_prod;
  logic [27:0] chs_base;
  logic        take;

  // Cylinder, head part of the CHS address: cyl*HEADS*SPT + head*SPT.
  // Both are multiplies by small constants.
  assign chs_base = 28'({tf.cyl_high_reg, tf.cyl_low_reg} * 32'(HS) +
                        {28'd0, tf.drive_head_reg[3:0]} * 32'(SECTORS_PER_TRACK));
  // Legacy capacity reported by identify: cylinders * heads * spt.
  assign chs_prod = 32'(cylinders) * 32'(HS);

  apr_core #(.HEADS(HEADS), .SECTORS_PER_TRACK(SECTORS_PER_TRACK)) u_core (
    .req(in_req.payload), .tf(tf), .disk_sectors(disk_sectors),
    .cylinders(cylinders), .chs_low(chs_prod[15:0]), .chs_high(chs_prod[31:16]),
    .chs_base(chs_base), .tf_next(tf_next), .rsp(rsp));

  // A new request is taken whenever the output register is empty or being
  // drained in the same cycle.
  assign in_req.ready = !out_valid || out_rsp.ready;
  assign take = in_req.valid && in_req.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tf <= TF_RESET;
      disk_sectors <= 28'd0;
      cylinders <= 16'd1;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_TOTAL: disk_sectors <= cfg.data;
          CFG_CYLS:  cylinders <= cfg.data[15:0];
          default: ;
        endcase
      end
      if (take) begin
        tf <= tf_next;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= rsp;
    end
  end

  assign out_rsp.valid = out_valid;
  assign out_rsp.payload = out_data;
endmodule

@@ sv/apr_checker.sv @@
// ----------------------------------------------------------------------------
// apr_checker
// Port-level checks of the ATA PIO read device, bound to the top level.
// ----------------------------------------------------------------------------
`include "ata_pio_read_device_assert.svh"
module apr_checker (
  input logic         clk,
  input logic         rst,
  input logic         in_valid,
  input logic         in_ready,
  input logic         out_valid,
  input logic         out_ready,
  input apr_pkg::rsp_t out_payload
);
  import apr_pkg::*;
  // A taken request always produces a response in the next cycle.
  `APR_ASSERT_NEXT(a_resp_follows, clk, rst, in_valid && in_ready, out_valid)
  // A stalled response stays put.
  `APR_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_payload))
  // Word position never passes the end of a sector.
  `APR_ASSERT_IMP(a_wpos, clk, rst, out_valid, out_payload.word_position <= 9'd256)
  // The position is a full sector only when the transfer has ended.
  `APR_ASSERT_IMP(a_end, clk, rst, out_valid && out_payload.word_position == 9'd256, !out_payload.transfer_active)
endmodule

bind ata_pio_read_device apr_checker u_apr_checker (
  .clk(clk), .rst(rst), .in_valid(in_req.valid), .in_ready(in_req.ready),
  .out_valid(out_rsp.valid), .out_ready(out_rsp.ready),
  .out_payload(out_rsp.payload));
